// ===== design/sspc_pkg.sv =====
package sspc_pkg;

    // Fixed field widths of the channels.
    localparam int OP_W         = 2;
    localparam int SLOT_FIELD_W = 3;
    localparam int OWNER_W      = 8;
    localparam int IN_COORD_W   = 24;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;

    // Defaults for the top-level parameters.
    localparam int SLOT_COUNT_DEF = 8;
    localparam int COORD_BITS_DEF = 24;

    // Each slot owns 2**SEL_W words in the box memory.
    localparam int SEL_W = 4;

    // Word select within a slot: {group, upper bound, axis}.
    localparam logic GRP_CMB = 1'b0;  // union box of older and newer segment
    localparam logic GRP_NEW = 1'b1;  // box of the newer segment
    localparam logic [SEL_W-1:0] SEL_OWNER = 4'b0011;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_SWEEP  = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS = 2'd0,
        KIND_PAIR   = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_BUSY  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEG,
        ST_MIN,
        ST_MAX,
        ST_WR_CLO,
        ST_WR_CHI,
        ST_WR_NLO,
        ST_WR_NHI,
        ST_WR_OWN,
        ST_STATUS,
        ST_PAIR,
        ST_OWN,
        ST_OV_A,
        ST_OV_B,
        ST_EMIT_PAIR,
        ST_NEXT,
        ST_EMIT_END
    } t_state;

    // Result of the shared comparator.
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    function automatic logic [SEL_W-1:0] fld_sel(logic grp, logic hi, logic [1:0] axis);
        fld_sel = {grp, hi, axis};
    endfunction

endpackage

// ===== design/sspc_in_if.sv =====
interface sspc_in_if;
    logic                                        valid;
    logic                                        ready;
    logic [sspc_pkg::OP_W-1:0]                   op;
    logic [sspc_pkg::SLOT_FIELD_W-1:0]           slot;
    logic [sspc_pkg::OWNER_W-1:0]                owner_id;
    logic signed [sspc_pkg::IN_COORD_W-1:0]      begin_x;
    logic signed [sspc_pkg::IN_COORD_W-1:0]      begin_y;
    logic signed [sspc_pkg::IN_COORD_W-1:0]      begin_z;
    logic signed [sspc_pkg::IN_COORD_W-1:0]      finish_x;
    logic signed [sspc_pkg::IN_COORD_W-1:0]      finish_y;
    logic signed [sspc_pkg::IN_COORD_W-1:0]      finish_z;

    modport source (
        output valid, op, slot, owner_id,
               begin_x, begin_y, begin_z, finish_x, finish_y, finish_z,
        input  ready
    );

    modport sink (
        input  valid, op, slot, owner_id,
               begin_x, begin_y, begin_z, finish_x, finish_y, finish_z,
        output ready
    );
endinterface

// ===== design/sspc_out_if.sv =====
interface sspc_out_if;
    logic                              valid;
    logic                              ready;
    logic [sspc_pkg::KIND_W-1:0]       kind;
    logic [sspc_pkg::STATUS_W-1:0]     status;
    logic [sspc_pkg::SLOT_FIELD_W-1:0] first_slot;
    logic [sspc_pkg::SLOT_FIELD_W-1:0] second_slot;
    logic [sspc_pkg::COUNT_W-1:0]      pair_count;
    logic                              last;

    modport source (
        output valid, kind, status, first_slot, second_slot, pair_count, last,
        input  ready
    );

    modport sink (
        input  valid, kind, status, first_slot, second_slot, pair_count, last,
        output ready
    );
endinterface

// ===== design/swept_segment_pair_collision_core.sv =====
// Channel   Dir  Modport  Handshake            Carries
// i_in      in   sink     valid/ready          op, slot, owner_id, begin_*, finish_*
// o_res     out  source   valid/ready          kind, status, first_slot, second_slot,
//                                              pair_count, last
//
// One item is worked at a time; i_in.ready is high only while the sequencer is idle.
// Add and update run seven steps per axis (order, min, max and four writes) through
// the one comparator and the single write port of the box memory; an add then writes
// the owner. Remove and a rejected op go straight to the status. A sweep skips a pair
// with an empty slot or equal owners, else runs the three-axis test and emits on overlap.
// Reset clears the slot valid bits, the output valid bit and the sequencer; the box memory needs no clearing.
// A result waits in the output register while the next item is accepted; the sequencer
// stalls only in a step that loads a result while that register is still full.
module swept_segment_pair_collision_core #(
    parameter int SLOT_COUNT = sspc_pkg::SLOT_COUNT_DEF,
    parameter int COORD_BITS = sspc_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sspc_in_if.sink     i_in,
    sspc_out_if.source  o_res
);
    import sspc_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int DEPTH  = SLOT_COUNT << SEL_W;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_W-1:0] PEN_SLOT  = SLOT_W'(SLOT_COUNT - 2);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // Sequencer and slot state.
    t_state                r_state, n_state;
    logic                  r_slot_valid [SLOT_COUNT];
    logic                  n_slot_valid [SLOT_COUNT];
    logic [1:0]            r_axis, n_axis;
    logic [SLOT_W-1:0]     r_i, n_i;
    logic [SLOT_W-1:0]     r_j, n_j;
    logic [COUNT_W-1:0]    r_count, n_count;
    t_status               r_status, n_status;

    // Captured item.
    t_op                   r_op;
    logic [SLOT_W-1:0]     r_slot;
    logic [OWNER_W-1:0]    r_owner;
    t_coord                r_beg [3];
    t_coord                r_fin [3];

    // Working values of the box update.
    t_coord                r_lo, n_lo;
    t_coord                r_hi, n_hi;
    t_coord                r_clo, n_clo;
    t_coord                r_chi, n_chi;
    t_coord                r_old_hi, n_old_hi;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    t_kind                 r_kind, n_kind;
    t_status               r_ostatus, n_ostatus;
    logic [SLOT_FIELD_W-1:0] r_first, n_first;
    logic [SLOT_FIELD_W-1:0] r_second, n_second;
    logic [COUNT_W-1:0]    r_pcount, n_pcount;
    logic                  r_last, n_last;

    // Memory and comparator hookup.
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COORD_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr_a;
    logic [ADDR_W-1:0]     mem_raddr_b;
    logic [COORD_BITS-1:0] mem_rdata_a;
    logic [COORD_BITS-1:0] mem_rdata_b;
    t_coord                rd_a, rd_b;
    t_coord                cmp_a, cmp_b;
    t_cmp                  cmp_res;

    logic                  accept;
    logic                  out_free;
    logic                  in_range;
    logic [SLOT_W-1:0]     in_slot;
    logic                  slot_hit;
    t_coord                old_lo, old_hi;
    logic [1:0]            axis_inc;

    sspc_box_mem #(
        .DEPTH  (DEPTH),
        .DATA_W (COORD_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    sspc_cmp #(
        .DATA_W (COORD_BITS)
    ) u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_res.ready;

    assign rd_a = t_coord'(mem_rdata_a);
    assign rd_b = t_coord'(mem_rdata_b);

    // A slot number beyond the table is rejected as empty.
    assign in_range = (32'(i_in.slot) < 32'(SLOT_COUNT));
    assign in_slot  = SLOT_W'(i_in.slot);
    assign slot_hit = in_range && r_slot_valid[in_slot];

    // An add has no older box, so its own segment stands in for it.
    assign old_lo   = (r_op == OP_ADD) ? r_lo : rd_a;
    assign old_hi   = (r_op == OP_ADD) ? r_hi : r_old_hi;
    assign axis_inc = r_axis + 2'd1;

    // Item capture. Coordinates are sign extended or wrapped to COORD_BITS.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_op'(i_in.op);
            r_slot   <= in_slot;
            r_owner  <= i_in.owner_id;
            r_beg[0] <= COORD_BITS'(i_in.begin_x);
            r_beg[1] <= COORD_BITS'(i_in.begin_y);
            r_beg[2] <= COORD_BITS'(i_in.begin_z);
            r_fin[0] <= COORD_BITS'(i_in.finish_x);
            r_fin[1] <= COORD_BITS'(i_in.finish_y);
            r_fin[2] <= COORD_BITS'(i_in.finish_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_slot_valid[k] <= 1'b0;
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_slot_valid <= n_slot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis    <= n_axis;
        r_i       <= n_i;
        r_j       <= n_j;
        r_count   <= n_count;
        r_status  <= n_status;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_clo     <= n_clo;
        r_chi     <= n_chi;
        r_old_hi  <= n_old_hi;
        r_kind    <= n_kind;
        r_ostatus <= n_ostatus;
        r_first   <= n_first;
        r_second  <= n_second;
        r_pcount  <= n_pcount;
        r_last    <= n_last;
    end

    always_comb begin
        n_state      = r_state;
        n_slot_valid = r_slot_valid;
        n_axis       = r_axis;
        n_i          = r_i;
        n_j          = r_j;
        n_count      = r_count;
        n_status     = r_status;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_clo        = r_clo;
        n_chi        = r_chi;
        n_old_hi     = r_old_hi;
        n_kind       = r_kind;
        n_ostatus    = r_ostatus;
        n_first      = r_first;
        n_second     = r_second;
        n_pcount     = r_pcount;
        n_last       = r_last;
        n_out_valid  = r_out_valid && !o_res.ready;

        mem_we      = 1'b0;
        mem_waddr   = {r_slot, fld_sel(GRP_CMB, 1'b0, r_axis)};
        mem_wdata   = COORD_BITS'(r_clo);
        mem_raddr_a = {r_slot, fld_sel(GRP_NEW, 1'b0, r_axis)};
        mem_raddr_b = {r_slot, fld_sel(GRP_NEW, 1'b1, r_axis)};
        cmp_a       = rd_a;
        cmp_b       = rd_b;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_axis   = AXIS_X;
                    n_status = STAT_OK;
                    case (t_op'(i_in.op))
                        OP_SWEEP: begin
                            n_i     = '0;
                            n_j     = SLOT_W'(1);
                            n_count = '0;
                            n_state = ST_PAIR;
                        end
                        OP_ADD: begin
                            if (!in_range) begin
                                n_status = STAT_EMPTY;
                                n_state  = ST_STATUS;
                            end else if (slot_hit) begin
                                n_status = STAT_BUSY;
                                n_state  = ST_STATUS;
                            end else begin
                                n_state = ST_SEG;
                            end
                        end
                        OP_REMOVE: begin
                            if (!slot_hit) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_slot_valid[in_slot] = 1'b0;
                            end
                            n_state = ST_STATUS;
                        end
                        default: begin
                            if (!slot_hit) begin
                                n_status = STAT_EMPTY;
                                n_state  = ST_STATUS;
                            end else begin
                                n_state = ST_SEG;
                            end
                        end
                    endcase
                end
            end

            // Order the new segment's two endpoints; the newer box is read meanwhile.
            ST_SEG: begin
                cmp_a = r_fin[r_axis];
                cmp_b = r_beg[r_axis];
                n_lo  = cmp_res.lt ? r_fin[r_axis] : r_beg[r_axis];
                n_hi  = cmp_res.lt ? r_beg[r_axis] : r_fin[r_axis];
                n_state = ST_MIN;
            end

            ST_MIN: begin
                cmp_a    = old_lo;
                cmp_b    = r_lo;
                n_clo    = cmp_res.lt ? old_lo : r_lo;
                n_old_hi = rd_b;
                n_state  = ST_MAX;
            end

            ST_MAX: begin
                cmp_a   = r_hi;
                cmp_b   = old_hi;
                n_chi   = cmp_res.lt ? old_hi : r_hi;
                n_state = ST_WR_CLO;
            end

            ST_WR_CLO: begin
                mem_we    = 1'b1;
                mem_waddr = {r_slot, fld_sel(GRP_CMB, 1'b0, r_axis)};
                mem_wdata = COORD_BITS'(r_clo);
                n_state   = ST_WR_CHI;
            end

            ST_WR_CHI: begin
                mem_we    = 1'b1;
                mem_waddr = {r_slot, fld_sel(GRP_CMB, 1'b1, r_axis)};
                mem_wdata = COORD_BITS'(r_chi);
                n_state   = ST_WR_NLO;
            end

            ST_WR_NLO: begin
                mem_we    = 1'b1;
                mem_waddr = {r_slot, fld_sel(GRP_NEW, 1'b0, r_axis)};
                mem_wdata = COORD_BITS'(r_lo);
                n_state   = ST_WR_NHI;
            end

            ST_WR_NHI: begin
                mem_we    = 1'b1;
                mem_waddr = {r_slot, fld_sel(GRP_NEW, 1'b1, r_axis)};
                mem_wdata = COORD_BITS'(r_hi);
                if (r_axis != AXIS_Z) begin
                    n_axis  = axis_inc;
                    n_state = ST_SEG;
                end else if (r_op == OP_ADD) begin
                    n_state = ST_WR_OWN;
                end else begin
                    n_state = ST_STATUS;
                end
            end

            // The owner shares the memory, zero extended, and the slot goes live.
            ST_WR_OWN: begin
                mem_we    = 1'b1;
                mem_waddr = {r_slot, SEL_OWNER};
                mem_wdata = {{(COORD_BITS - OWNER_W){1'b0}}, r_owner};
                n_slot_valid[r_slot] = 1'b1;
                n_state   = ST_STATUS;
            end

            ST_STATUS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_STATUS;
                    n_ostatus   = r_status;
                    n_first     = '0;
                    n_second    = '0;
                    n_pcount    = '0;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            // Sweep: fetch both owners when both slots are live.
            ST_PAIR: begin
                mem_raddr_a = {r_i, SEL_OWNER};
                mem_raddr_b = {r_j, SEL_OWNER};
                if (r_slot_valid[r_i] && r_slot_valid[r_j]) begin
                    n_state = ST_OWN;
                end else begin
                    n_state = ST_NEXT;
                end
            end

            ST_OWN: begin
                mem_raddr_a = {r_i, fld_sel(GRP_CMB, 1'b0, AXIS_X)};
                mem_raddr_b = {r_j, fld_sel(GRP_CMB, 1'b1, AXIS_X)};
                n_axis      = AXIS_X;
                if (cmp_res.eq) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_OV_A;
                end
            end

            // Separated when the upper bound of j lies below the lower bound of i.
            ST_OV_A: begin
                cmp_a       = rd_b;
                cmp_b       = rd_a;
                mem_raddr_a = {r_i, fld_sel(GRP_CMB, 1'b1, r_axis)};
                mem_raddr_b = {r_j, fld_sel(GRP_CMB, 1'b0, r_axis)};
                if (cmp_res.lt) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_OV_B;
                end
            end

            // Separated when the upper bound of i lies below the lower bound of j.
            ST_OV_B: begin
                cmp_a       = rd_a;
                cmp_b       = rd_b;
                mem_raddr_a = {r_i, fld_sel(GRP_CMB, 1'b0, axis_inc)};
                mem_raddr_b = {r_j, fld_sel(GRP_CMB, 1'b1, axis_inc)};
                if (cmp_res.lt) begin
                    n_state = ST_NEXT;
                end else if (r_axis == AXIS_Z) begin
                    n_state = ST_EMIT_PAIR;
                end else begin
                    n_axis  = axis_inc;
                    n_state = ST_OV_A;
                end
            end

            ST_EMIT_PAIR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_PAIR;
                    n_ostatus   = STAT_OK;
                    n_first     = SLOT_FIELD_W'(r_i);
                    n_second    = SLOT_FIELD_W'(r_j);
                    n_pcount    = '0;
                    n_last      = 1'b0;
                    n_count     = r_count + COUNT_W'(1);
                    n_state     = ST_NEXT;
                end
            end

            // Step to the next pair i < j in row order.
            ST_NEXT: begin
                if (r_j != LAST_SLOT) begin
                    n_j     = r_j + SLOT_W'(1);
                    n_state = ST_PAIR;
                end else if (r_i == PEN_SLOT) begin
                    n_state = ST_EMIT_END;
                end else begin
                    n_i     = r_i + SLOT_W'(1);
                    n_j     = SLOT_W'(32'(r_i) + 32'd2);
                    n_state = ST_PAIR;
                end
            end

            ST_EMIT_END: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_END;
                    n_ostatus   = STAT_OK;
                    n_first     = '0;
                    n_second    = '0;
                    n_pcount    = r_count;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_kind;
    assign o_res.status      = r_ostatus;
    assign o_res.first_slot  = r_first;
    assign o_res.second_slot = r_second;
    assign o_res.pair_count  = r_pcount;
    assign o_res.last        = r_last;

`ifndef NO_ASSERTIONS
    // A pair always names the lower slot first.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_PAIR)) |-> (o_res.first_slot < o_res.second_slot))
        else $error("pair result with slots out of order");

    // The box memory is written only while an item is being worked.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != ST_IDLE))
        else $error("box memory written while idle");

    // Once an item is taken the input closes for at least the next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input reopened right after an accept");

    // A sweep end result always closes its item.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_END)) |-> o_res.last)
        else $error("sweep end without last");
`endif

endmodule

// ===== design/sspc_box_mem.sv =====
module sspc_box_mem #(
    parameter int DEPTH  = sspc_pkg::SLOT_COUNT_DEF << sspc_pkg::SEL_W,
    parameter int DATA_W = sspc_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [DATA_W-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic [DATA_W-1:0]          o_rdata_a,
    output logic [DATA_W-1:0]          o_rdata_b
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

// ===== design/sspc_cmp.sv =====
module sspc_cmp #(
    parameter int DATA_W = sspc_pkg::COORD_BITS_DEF
) (
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output sspc_pkg::t_cmp           o_res
);
    import sspc_pkg::*;

    // One signed compare serves every endpoint order, min, max, overlap and owner test.
    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
    end
endmodule
